### src/swm_pkg.sv
// ============================================================================
// swm_pkg - shared types and constants for the sliding window maximum
// Position, window length and cell control types, plus register map codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Sample positions wrap modulo 2^16
    localparam int POS_WIDTH = 16;

    // Width of the window_length register field
    localparam int WLEN_WIDTH = 7;

    // APB address: one 32-bit register, word index at bit 2
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_INDEX_LSB  = 2;

    typedef logic [POS_WIDTH-1:0]  pos_t;
    typedef logic [WLEN_WIDTH-1:0] wlen_t;

    // Register index codes
    typedef enum logic
    {
        REG_WINDOW_LENGTH = 1'b0,
        REG_UNMAPPED      = 1'b1
    } reg_idx_t;

    // Status a cell presents to its neighbors
    typedef struct packed
    {
        logic valid;    // cell holds a deque entry
        logic pop;      // entry is not larger than the incoming sample
        logic expired;  // entry has left the window
    } cell_stat_t;

    // Control broadcast to every cell
    typedef struct packed
    {
        logic advance;  // a sample transaction is taken this cycle
        logic shift;    // drop the front entry: take data from the right neighbor
        logic clear;    // start of stream: discard all held entries
    } cell_ctrl_t;

endpackage

`default_nettype wire

### src/swm_in_if.sv
// ============================================================================
// swm_in_if - sample input channel
// Valid/ready channel carrying one signed sample and the start flag.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface swm_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_of_stream;

    modport source (output valid, output sample, output start_of_stream, input ready);
    modport sink   (input valid, input sample, input start_of_stream, output ready);
endinterface

`default_nettype wire

### src/swm_out_if.sv
// ============================================================================
// swm_out_if - window maximum output channel
// Valid/ready channel carrying one signed window maximum.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface swm_out_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

### src/sliding_window_maximum.sv
// ============================================================================
// sliding_window_maximum - running maximum over the last K signed samples
// Monotonic deque built as a row of cells, front entry in cell 0.
// ============================================================================
// Usage:
//   sample_stream carries one signed sample and a start_of_stream flag per
//   transaction. max_stream carries one window_max per transaction, issued
//   once K samples have been seen since reset or the last start flag.
//   window_length (K) is written over the APB port at address 0 while idle;
//   the user must keep to this, as the block does not enforce it. 0 acts as 1
//   and values above MAX_WINDOW act as MAX_WINDOW.
// Result timing and throughput:
//   A result is registered and valid in the cycle after its sample is taken.
//   One sample per cycle is taken in steady state while the output does not
//   stall, since at most one front entry expires per sample. After K shrinks,
//   purge shifts of all cells drop extra expired entries, taking no sample.
// Reset:
//   All deque cells empty, position and seen counters zero, K = 1.
// Stall:
//   The result sits in an output register; a new sample is taken while no
//   purge runs and the register is empty or being emptied in the same cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_maximum #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    // APB configuration port
    input  wire                                      psel,
    input  wire                                      penable,
    input  wire                                      pwrite,
    input  wire logic [swm_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  wire logic [swm_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [swm_pkg::APB_DATA_WIDTH-1:0]       prdata,
    output logic                                     pready,
    // streams
    swm_in_if.sink                                   sample_stream,
    swm_out_if.source                                max_stream
);
    import swm_pkg::*;

    localparam int KW = $clog2(MAX_WINDOW + 1);

    wlen_t                          window_length_reg;
    logic [KW-1:0]                  k;
    pos_t                           sample_position_reg, sample_position_next;
    pos_t                           new_pos;
    logic [KW-1:0]                  samples_seen_reg, samples_seen_next;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] window_max_reg;
    logic                           in_acc;
    logic                           emit;
    logic                           purge;
    logic                           drop_front;
    reg_idx_t                       reg_idx;
    cell_ctrl_t                     ctrl;

    cell_stat_t                     stat_w   [MAX_WINDOW+1];
    logic signed [SAMPLE_WIDTH-1:0] value_w  [MAX_WINDOW+1];
    pos_t                           pos_w    [MAX_WINDOW+1];
    logic                           keep_w   [MAX_WINDOW+1];
    logic signed [SAMPLE_WIDTH-1:0] front_w  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]          valid_vec;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[REG_INDEX_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= wlen_t'(1);
        end
        else if (psel && penable && pwrite && pready && reg_idx == REG_WINDOW_LENGTH)
        begin
            window_length_reg <= pwdata[WLEN_WIDTH-1:0];
        end
    end

    // Decode read data
    always_comb
    begin
        unique case (reg_idx)
            REG_WINDOW_LENGTH: prdata = APB_DATA_WIDTH'(window_length_reg);
            default:           prdata = '0;
        endcase
    end

    // Clamp window length to 1..MAX_WINDOW
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            k = KW'(1);
        end
        else if (int'(window_length_reg) > MAX_WINDOW)
        begin
            k = KW'(MAX_WINDOW);
        end
        else
        begin
            k = KW'(window_length_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake and cell control
    // ------------------------------------------------------------------
    // Purge while a second front entry has also expired
    generate
        if (MAX_WINDOW > 1)
        begin : g_purge
            assign purge = stat_w[1].expired;
        end
        else
        begin : g_no_purge
            assign purge = 1'b0;
        end
    endgenerate

    assign sample_stream.ready = !purge && (!out_valid_reg || max_stream.ready);
    assign in_acc              = sample_stream.valid && sample_stream.ready;
    assign drop_front          = stat_w[0].expired && !sample_stream.start_of_stream;

    assign ctrl.advance = in_acc;
    assign ctrl.shift   = in_acc ? drop_front : purge;
    assign ctrl.clear   = sample_stream.start_of_stream;

    assign new_pos = sample_stream.start_of_stream ? '0 : sample_position_reg;
    assign sample_position_next = new_pos + pos_t'(1);

    // Count samples seen, saturating at K
    always_comb
    begin
        samples_seen_next = sample_stream.start_of_stream ? '0 : samples_seen_reg;
        if (samples_seen_next > k)
        begin
            samples_seen_next = k;
        end
        if (samples_seen_next < k)
        begin
            samples_seen_next = KW'(samples_seen_next + 1'b1);
        end
    end

    assign emit = samples_seen_next >= k;

    // ------------------------------------------------------------------
    // Deque cells, front at index 0
    // ------------------------------------------------------------------
    assign keep_w[0]           = 1'b1;
    assign stat_w[MAX_WINDOW]  = '0;
    assign value_w[MAX_WINDOW] = '0;
    assign pos_w[MAX_WINDOW]   = '0;

    generate
        for (genvar i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .KW           (KW)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctrl           (ctrl),
                .sample         (sample_stream.sample),
                .cur_pos        (sample_position_reg),
                .new_pos        (new_pos),
                .k              (k),
                .right_stat     (stat_w[i+1]),
                .right_value    (value_w[i+1]),
                .right_pos      (pos_w[i+1]),
                .left_keep      (keep_w[i]),
                .stat           (stat_w[i]),
                .value          (value_w[i]),
                .pos            (pos_w[i]),
                .keep           (keep_w[i+1]),
                .value_next_out (front_w[i])
            );
            assign valid_vec[i] = stat_w[i].valid;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Counters and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_position_reg <= '0;
            samples_seen_reg    <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                sample_position_reg <= sample_position_next;
                samples_seen_reg    <= samples_seen_next;
            end
            if (in_acc && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (max_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the new front value as the window maximum
    always_ff @(posedge clk)
    begin
        if (in_acc && emit)
        begin
            window_max_reg <= front_w[0];
        end
    end

    assign max_stream.valid      = out_valid_reg;
    assign max_stream.window_max = window_max_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Occupied cells always form a contiguous run from the front
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("deque cells not contiguous from the front");

    // A taken sample always leaves the front cell occupied
    a_front: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> stat_w[0].valid)
        else $error("front cell empty after a sample transaction");

    // An emitting sample shows its result on the next cycle
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && emit) |=> max_stream.valid)
        else $error("window maximum not presented after emitting sample");

    // No purge shift while a transaction is taken
    a_purge: assert property (@(posedge clk) disable iff (!rst_n)
        purge |-> !in_acc && ctrl.shift)
        else $error("purge overlapped a sample transaction");

endmodule

`default_nettype wire

### src/swm_cell.sv
// ============================================================================
// swm_cell - one slot of the monotonic deque
// Holds one (value, position) entry. Compares it against the incoming sample
// and the window, and either keeps its source entry, takes the new sample as
// the new tail, or goes empty. Source is itself or its right neighbor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int KW           = 7
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire swm_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   sample,
    input  wire swm_pkg::pos_t                    cur_pos,
    input  wire swm_pkg::pos_t                    new_pos,
    input  wire logic [KW-1:0]                    k,
    // right neighbor (toward the back of the deque)
    input  wire swm_pkg::cell_stat_t              right_stat,
    input  wire logic signed [SAMPLE_WIDTH-1:0]   right_value,
    input  wire swm_pkg::pos_t                    right_pos,
    // left neighbor keeps its entry
    input  wire                                   left_keep,
    output swm_pkg::cell_stat_t                   stat,
    output logic signed [SAMPLE_WIDTH-1:0]        value,
    output swm_pkg::pos_t                         pos,
    output logic                                  keep,
    output logic signed [SAMPLE_WIDTH-1:0]        value_next_out
);
    import swm_pkg::*;

    logic                           valid_reg, valid_next;
    logic signed [SAMPLE_WIDTH-1:0] value_reg, value_next;
    pos_t                           position_reg, position_next;
    pos_t                           age;
    cell_stat_t                     src_stat;
    logic signed [SAMPLE_WIDTH-1:0] src_value;
    pos_t                           src_pos;

    // Compare own entry against the window and the incoming sample
    assign age          = cur_pos - position_reg;
    assign stat.valid   = valid_reg;
    assign stat.pop     = valid_reg && (value_reg <= sample);
    assign stat.expired = valid_reg && (age >= pos_t'(k));
    assign value        = value_reg;
    assign pos          = position_reg;

    // Select source entry: own, or right neighbor when the front drops
    assign src_stat  = ctrl.shift ? right_stat  : stat;
    assign src_value = ctrl.shift ? right_value : value_reg;
    assign src_pos   = ctrl.shift ? right_pos   : position_reg;

    assign keep = src_stat.valid && !src_stat.pop && !ctrl.clear;

    // Next entry: keep source, append the sample as tail, or go empty
    always_comb
    begin
        valid_next    = valid_reg;
        value_next    = value_reg;
        position_next = position_reg;
        if (ctrl.advance)
        begin
            valid_next    = keep || left_keep;
            value_next    = keep ? src_value : sample;
            position_next = keep ? src_pos   : new_pos;
        end
        else if (ctrl.shift)
        begin
            valid_next    = right_stat.valid;
            value_next    = right_value;
            position_next = right_pos;
        end
    end

    assign value_next_out = value_next;

    // Hold the entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        position_reg <= position_next;
    end

endmodule

`default_nettype wire
